>>> src/drrip_pkg.sv
// Shared types, constants and helper functions for the DRRIP victim select unit.
package drrip_pkg;

   // Default geometry and register reset values.
   localparam int unsigned NUM_SETS_DEF   = 1024;
   localparam int unsigned NUM_WAYS_DEF   = 16;
   localparam int unsigned RRPV_BITS_DEF  = 2;
   localparam int unsigned LEADER_SPACING = 64;
   localparam int unsigned LEADER_SHIFT   = $clog2(LEADER_SPACING);
   localparam logic [31:0] EPOCH_RESET    = 32'd6000000;
   localparam logic [7:0]  PERIOD_RESET   = 8'd32;

   // Configuration register indexes.
   localparam logic [7:0] CSR_EPOCH_LENGTH   = 8'd0;
   localparam logic [7:0] CSR_BIMODAL_PERIOD = 8'd1;

   // Request codes.
   localparam logic REQ_TOUCH = 1'b0;
   localparam logic REQ_MISS  = 1'b1;

   // Leader set classes.
   typedef enum logic [1:0] {
      LEADER_BRRIP,
      LEADER_SRRIP,
      LEADER_NONE
   } leader_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic read;
      logic eval;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

   // Reduces a set index modulo the set count by conditional subtraction.
   // The set count is at least 64, so four steps cover a 10-bit index.
   function automatic logic [16:0] set_fold(input logic [9:0] idx, input int unsigned nsets);
      logic [16:0] r;
      logic [20:0] m;
      r = {7'd0, idx};
      for (int k = 3; k >= 0; k--) begin
         m = 21'(nsets) << k;
         if ({4'd0, r} >= m) begin
            r = 17'({4'd0, r} - m);
         end
      end
      return r;
   endfunction

   // Classifies a set as BRRIP leader, SRRIP leader or follower.
   function automatic leader_type leader_of(input logic [16:0] s);
      logic [16:0] b;
      logic [16:0] a;
      b = s - (s >> LEADER_SHIFT);
      a = s + 17'd1 + (s >> LEADER_SHIFT);
      if (b[LEADER_SHIFT-1:0] == '0) begin
         return LEADER_BRRIP;
      end else if (a[LEADER_SHIFT-1:0] == '0) begin
         return LEADER_SRRIP;
      end
      return LEADER_NONE;
   endfunction

endpackage

>>> src/drrip_ctrl.sv
// Controller state machine that sequences clearing, reads, evaluation and result hand-off.
module drrip_ctrl
   import drrip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_OUT;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_READ: cmd.read = 1'b1;
         ST_EVAL: cmd.eval = 1'b1;
         ST_OUT:  cmd.load_out = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> src/drrip_dp.sv
// Datapath: input latch, RRPV row memory, dueling state, victim logic and output register.
module drrip_dp
   import drrip_pkg::*;
#(
   parameter int unsigned NUM_SETS  = NUM_SETS_DEF,
   parameter int unsigned NUM_WAYS  = NUM_WAYS_DEF,
   parameter int unsigned RRPV_BITS = RRPV_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_req_type,
   input  logic [9:0]  req_set_index,
   input  logic [3:0]  req_hit_way,
   input  logic        req_is_structure,
   input  logic [15:0] req_valid_mask,
   input  logic [47:0] req_instr_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_victim_way,
   output logic        rsp_filled_invalid,
   output logic        rsp_policy_is_srrip,
   input  logic        csr_valid,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned SET_W = $clog2(NUM_SETS);
   localparam int unsigned WAY_W = $clog2(NUM_WAYS);
   localparam int unsigned HALF  = NUM_WAYS / 2;
   localparam int unsigned RMAX  = (1 << RRPV_BITS) - 1;
   localparam int unsigned RLONG = RMAX - 1;
   localparam int unsigned ROW_W = NUM_WAYS * RRPV_BITS;
   localparam int unsigned MEM_W = ROW_W + WAY_W;
   localparam int unsigned VM_W  = (NUM_WAYS > 16) ? NUM_WAYS : 16;

   localparam logic [RRPV_BITS-1:0] RV_MAX  = RRPV_BITS'(RMAX);
   localparam logic [RRPV_BITS-1:0] RV_LONG = RRPV_BITS'(RLONG);

   // Configuration registers.
   logic [31:0] epoch_length_ff;
   logic [7:0]  bimodal_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_length_ff   <= EPOCH_RESET;
         bimodal_period_ff <= PERIOD_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_EPOCH_LENGTH) epoch_length_ff <= csr_wdata;
         if (csr_index == CSR_BIMODAL_PERIOD) bimodal_period_ff <= csr_wdata[7:0];
      end
   end

   // Input beat latch.
   logic                 type_ff;
   logic [SET_W-1:0]     set_ff;
   logic [3:0]           hway_ff;
   logic                 struct_ff;
   logic [NUM_WAYS-1:0]  valid_ff;
   logic [47:0]          icount_ff;
   logic [16:0]          set_fold_w;

   assign set_fold_w = set_fold(req_set_index, NUM_SETS);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff   <= req_req_type;
         set_ff    <= set_fold_w[SET_W-1:0];
         hway_ff   <= req_hit_way;
         struct_ff <= req_is_structure;
         valid_ff  <= NUM_WAYS'(VM_W'(req_valid_mask));
         icount_ff <= req_instr_count;
      end
   end

   // Clearing pass over the row memory after reset.
   logic [SET_W-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clear_last = (32'(clr_cnt_ff) == NUM_SETS - 1);

   // Row memory: scan pointer above the packed RRPV values of the set.
   logic [MEM_W-1:0] mem [NUM_SETS];
   logic [MEM_W-1:0] rd_ff;
   logic [MEM_W-1:0] wr_data;
   logic [SET_W-1:0] wr_addr;
   logic             wr_en;
   logic [MEM_W-1:0] row_new;

   assign wr_en   = cmd.clear | cmd.eval;
   assign wr_addr = cmd.clear ? clr_cnt_ff : set_ff;
   assign wr_data = cmd.clear ? {WAY_W'(0), {NUM_WAYS{RV_LONG}}} : row_new;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.read) rd_ff <= mem[set_ff];
   end

   // Epoch boundary product, registered before the compare.
   logic [31:0] epoch_num_ff;
   logic [64:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         prod_ff <= 65'(epoch_length_ff) * 65'({1'b0, epoch_num_ff} + 33'd1);
      end
   end

   // Dueling state.
   logic        winner_ff;
   logic [31:0] srrip_miss_ff, brrip_miss_ff;
   logic [7:0]  bim_plain_ff, bim_struct_ff;

   // Evaluation of one beat.
   logic                 close_epoch;
   logic                 winner_new;
   logic [31:0]          srrip_new, brrip_new;
   logic [7:0]           bim_plain_new, bim_struct_new;
   logic [7:0]           bim_cur, bim_next;
   leader_type           leader;
   logic [RRPV_BITS-1:0] rr [NUM_WAYS];
   logic [RRPV_BITS-1:0] rr_new [NUM_WAYS];
   logic [NUM_WAYS-1:0]  in_part;
   logic [WAY_W-1:0]     ptr;
   logic [WAY_W-1:0]     ptr_new;
   logic                 inv_found, scan_found;
   int unsigned          inv_way, scan_way, wsel;
   logic [WAY_W-1:0]     victim;
   logic [RRPV_BITS-1:0] part_max, age;
   logic                 use_bim;
   logic [RRPV_BITS-1:0] ins_val;
   logic [3:0]           res_way;
   logic                 res_filled;

   always_comb begin
      // Only a miss can close an epoch.
      close_epoch = (type_ff == REQ_MISS) && ({17'd0, icount_ff} >= prod_ff);
      winner_new  = close_epoch ? (brrip_miss_ff > srrip_miss_ff) : winner_ff;
      srrip_new   = close_epoch ? 32'd0 : srrip_miss_ff;
      brrip_new   = close_epoch ? 32'd0 : brrip_miss_ff;
      leader      = leader_of(17'(set_ff));
      ptr         = rd_ff[ROW_W +: WAY_W];

      // Unpack the row and mark the partition.
      for (int w = 0; w < NUM_WAYS; w++) begin
         rr[w]      = rd_ff[w*RRPV_BITS +: RRPV_BITS];
         in_part[w] = struct_ff ? (w >= HALF) : (w < HALF);
      end

      // First invalid way of the partition, and the partition's highest RRPV.
      inv_found = 1'b0;
      inv_way   = 0;
      part_max  = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (in_part[w] && !valid_ff[w] && !inv_found) begin
            inv_found = 1'b1;
            inv_way   = w;
         end
         if (in_part[w] && rr[w] > part_max) part_max = rr[w];
      end

      // Aging lifts the partition's highest value to the maximum; the scan
      // then finds the first way at that value circularly from the pointer.
      age        = RV_MAX - part_max;
      scan_found = 1'b0;
      scan_way   = 0;
      for (int k = 0; k < NUM_WAYS; k++) begin
         wsel = 32'(ptr) + k;
         if (wsel >= NUM_WAYS) wsel = wsel - NUM_WAYS;
         if (in_part[wsel] && rr[wsel] == part_max && !scan_found) begin
            scan_found = 1'b1;
            scan_way   = wsel;
         end
      end

      victim = inv_found ? WAY_W'(inv_way) : WAY_W'(scan_way);

      // Insertion value and bimodal counters.
      bim_plain_new  = bim_plain_ff;
      bim_struct_new = bim_struct_ff;
      bim_cur        = struct_ff ? bim_struct_ff : bim_plain_ff;
      bim_next       = bim_cur + 8'd1;
      if (bim_next == bimodal_period_ff) bim_next = 8'd0;
      if (struct_ff) begin
         use_bim = !winner_new;
      end else begin
         case (leader)
            LEADER_BRRIP: begin
               use_bim = 1'b1;
               if (brrip_new != '1) brrip_new = brrip_new + 32'd1;
            end
            LEADER_SRRIP: begin
               use_bim = 1'b0;
               if (srrip_new != '1) srrip_new = srrip_new + 32'd1;
            end
            default: use_bim = !winner_new;
         endcase
      end
      if (use_bim) begin
         ins_val = (bim_next == 8'd0) ? RV_LONG : RV_MAX;
         if (struct_ff) bim_struct_new = bim_next;
         else bim_plain_new = bim_next;
      end else begin
         ins_val = RV_LONG;
      end

      // New row contents.
      ptr_new = ptr;
      for (int w = 0; w < NUM_WAYS; w++) begin
         rr_new[w] = rr[w];
      end
      if (type_ff == REQ_TOUCH) begin
         if (32'(hway_ff) < NUM_WAYS) rr_new[hway_ff[WAY_W-1:0]] = '0;
         res_way    = hway_ff;
         res_filled = 1'b0;
      end else begin
         if (!inv_found) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (in_part[w]) rr_new[w] = rr[w] + age;
            end
            ptr_new = (32'(victim) + 1 >= NUM_WAYS) ? '0 : WAY_W'(32'(victim) + 1);
         end
         rr_new[victim] = ins_val;
         res_way    = 4'(victim);
         res_filled = inv_found;
      end

      row_new[ROW_W +: WAY_W] = ptr_new;
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_new[w*RRPV_BITS +: RRPV_BITS] = rr_new[w];
      end
   end

   // Dueling state updates on misses.
   always_ff @(posedge clock) begin
      if (reset) begin
         winner_ff     <= 1'b0;
         epoch_num_ff  <= '0;
         srrip_miss_ff <= '0;
         brrip_miss_ff <= '0;
         bim_plain_ff  <= '0;
         bim_struct_ff <= '0;
      end else if (cmd.eval && type_ff == REQ_MISS) begin
         winner_ff     <= winner_new;
         epoch_num_ff  <= close_epoch ? epoch_num_ff + 32'd1 : epoch_num_ff;
         srrip_miss_ff <= srrip_new;
         brrip_miss_ff <= brrip_new;
         bim_plain_ff  <= bim_plain_new;
         bim_struct_ff <= bim_struct_new;
      end
   end

   // Result hold and output register.
   logic [3:0] res_way_ff;
   logic       res_filled_ff, res_policy_ff;
   logic       rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         res_way_ff    <= res_way;
         res_filled_ff <= res_filled;
         res_policy_ff <= winner_new;
      end
      if (cmd.load_out) begin
         rsp_victim_way      <= res_way_ff;
         rsp_filled_invalid  <= res_filled_ff;
         rsp_policy_is_srrip <= res_policy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

>>> src/drrip_partitioned_victim_select_unit.sv
// Top level of the partitioned DRRIP victim select unit.
// Each beat passes through accept, row memory read with epoch boundary multiply,
// evaluation with row write-back, and result hand-off; one beat is in flight at a time.
// The result is loaded into the output register for rsp_valid once the result side is free.
// After reset the row memory is cleared one set per cycle, over all NUM_SETS sets, while
// req_stall stays high; configuration writes are taken throughout.
module drrip_partitioned_victim_select_unit
   import drrip_pkg::*;
#(
   parameter int unsigned NUM_SETS  = NUM_SETS_DEF,
   parameter int unsigned NUM_WAYS  = NUM_WAYS_DEF,
   parameter int unsigned RRPV_BITS = RRPV_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_req_type,
   input  logic [9:0]  req_set_index,
   input  logic [3:0]  req_hit_way,
   input  logic        req_is_structure,
   input  logic [15:0] req_valid_mask,
   input  logic [47:0] req_instr_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_victim_way,
   output logic        rsp_filled_invalid,
   output logic        rsp_policy_is_srrip,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   drrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   drrip_dp #(
      .NUM_SETS  (NUM_SETS),
      .NUM_WAYS  (NUM_WAYS),
      .RRPV_BITS (RRPV_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_req_type        (req_req_type),
      .req_set_index       (req_set_index),
      .req_hit_way         (req_hit_way),
      .req_is_structure    (req_is_structure),
      .req_valid_mask      (req_valid_mask),
      .req_instr_count     (req_instr_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_victim_way      (rsp_victim_way),
      .rsp_filled_invalid  (rsp_filled_invalid),
      .rsp_policy_is_srrip (rsp_policy_is_srrip),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

endmodule

>>> src/drrip_checker.sv
// Port-level checker for the DRRIP victim select unit and its bind.
module drrip_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_victim_way,
   input logic       csr_ready
);

   // Reset empties the result side and starts the clearing pass.
   a_reset_state: assert property (@(posedge clock) reset |=> !rsp_valid && req_stall)
      else $error("reset did not empty the result side or start clearing");

   // Only one beat is in flight, so an accept closes the request side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open right after an accept");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_victim_way))
      else $error("stalled result beat changed");

   // A result never appears in the cycle right after an accept.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared too early");

   // Configuration writes are never refused.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind drrip_partitioned_victim_select_unit drrip_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_victim_way (rsp_victim_way),
   .csr_ready      (csr_ready)
);
